// ===== rtl/core/tsrw_pkg.sv =====
// Package for the timestamp reorder window: widths, result kinds and the
// record and control types shared by the cell chain and the top level.
// No dependencies.
package tsrw_pkg;

    // Store geometry
    localparam int STORE_DEPTH = 32;
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

    // Field widths
    localparam int SEC_W  = 32;
    localparam int MIC_W  = 20;
    localparam int KEY_W  = SEC_W + MIC_W;
    localparam int TAG_W  = 16;
    localparam int WIN_W  = 6;
    localparam int KIND_W = 2;

    // Width used to compare the fill count against the window register
    localparam int CMP_W = (CNT_W > WIN_W) ? CNT_W : WIN_W;

    // Reset value of the window register
    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(32);

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_PACKET = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END    = 2'd2;

    // One stored record: timestamp key (seconds above micros) and tag
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } t_rec;

    // Chain-wide command, one per cycle
    typedef struct packed {
        logic insert;
        logic pop;
        logic clear;
    } t_cell_ctl;

endpackage

// ===== rtl/core/tsrw_cell.sv =====
// One cell of the sorted insertion chain: holds a record and its valid flag,
// and shifts toward the tail on insert or toward the head on pop.
// Depends on tsrw_pkg.
module tsrw_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tsrw_pkg::t_cell_ctl i_ctl,
    input  tsrw_pkg::t_rec      i_new,
    input  tsrw_pkg::t_rec      i_prev_rec,
    input  logic                i_prev_valid,
    input  logic                i_prev_ge,
    input  tsrw_pkg::t_rec      i_next_rec,
    input  logic                i_next_valid,
    output tsrw_pkg::t_rec      o_rec,
    output logic                o_valid,
    output logic                o_ge
);
    import tsrw_pkg::*;

    logic r_valid;
    logic n_valid;
    t_rec r_rec;
    t_rec n_rec;

    // Held record stays ahead of the new one (ties keep arrival order)
    assign o_ge    = r_valid && (r_rec.key <= i_new.key);
    assign o_rec   = r_rec;
    assign o_valid = r_valid;

    // Pick next contents: keep, take the new record, or take a neighbor's
    always_comb begin
        n_valid = r_valid;
        n_rec   = r_rec;
        if (i_ctl.clear) begin
            n_valid = 1'b0;
        end else if (i_ctl.insert) begin
            if (!o_ge) begin
                if (i_prev_ge) begin
                    n_valid = 1'b1;
                    n_rec   = i_new;
                end else begin
                    n_valid = i_prev_valid;
                    n_rec   = i_prev_rec;
                end
            end
        end else if (i_ctl.pop) begin
            n_valid = i_next_valid;
            n_rec   = i_next_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

endmodule

// ===== rtl/core/timestamp_reorder_window_top.sv =====
// Timestamp reorder window: a packet record, unless the chain is full or the
// run has failed, is inserted into the sorted chain of STORE_DEPTH cells; then
// the head cell is compared against the window and the last released timestamp,
// and a release waits in that check while the output register is held. After an
// end item is accepted, each stored record and then the end marker leave through
// the single output register. Records leave oldest first, equal timestamps in
// arrival order; no clearing pass is needed after reset.
// Depends on tsrw_pkg and tsrw_cell.
module timestamp_reorder_window_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Configuration
    input  logic                         i_cfg_we,
    input  logic [tsrw_pkg::WIN_W-1:0]   i_cfg_data,
    // Input channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_mode,
    input  logic [tsrw_pkg::SEC_W-1:0]   i_time_seconds,
    input  logic [tsrw_pkg::MIC_W-1:0]   i_time_micros,
    input  logic [tsrw_pkg::TAG_W-1:0]   i_packet_tag,
    // Output channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [tsrw_pkg::KIND_W-1:0]  o_kind,
    output logic [tsrw_pkg::SEC_W-1:0]   o_out_seconds,
    output logic [tsrw_pkg::MIC_W-1:0]   o_out_micros,
    output logic [tsrw_pkg::TAG_W-1:0]   o_out_tag,
    output logic                         o_run_failed,
    output logic                         o_last
);
    import tsrw_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [KEY_W-1:0] r_last_rel;
    logic [KEY_W-1:0] n_last_rel;
    logic             r_failed;
    logic             n_failed;
    logic [WIN_W-1:0] r_window;

    logic              r_ovalid;
    logic              n_ovalid;
    logic [KIND_W-1:0] r_okind;
    logic [KIND_W-1:0] n_okind;
    logic [KEY_W-1:0]  r_okey;
    logic [KEY_W-1:0]  n_okey;
    logic [TAG_W-1:0]  r_otag;
    logic [TAG_W-1:0]  n_otag;
    logic              r_ofail;
    logic              n_ofail;
    logic              r_olast;
    logic              n_olast;

    t_cell_ctl              w_ctl;
    t_rec                   w_new;
    t_rec                   w_rec [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] w_valid;
    logic [STORE_DEPTH-1:0] w_ge;

    logic             w_in_acc;
    logic             w_ofree;
    logic             w_full;
    logic [CMP_W-1:0] w_win;
    logic             w_reach;

    // Handshakes
    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_ofree    = !r_ovalid || !i_out_stall;

    assign w_new.key = {i_time_seconds, i_time_micros};
    assign w_new.tag = i_packet_tag;

    assign w_full = (r_count == CNT_W'(STORE_DEPTH));

    // Clamp the window to the range one to STORE_DEPTH
    always_comb begin
        w_win = CMP_W'(r_window);
        if (r_window == '0) begin
            w_win = CMP_W'(1);
        end else if (CMP_W'(r_window) > CMP_W'(STORE_DEPTH)) begin
            w_win = CMP_W'(STORE_DEPTH);
        end
    end
    assign w_reach = (CMP_W'(r_count) >= w_win);

    // Cell chain, head cell holds the oldest record
    for (genvar g = 0; g < STORE_DEPTH; g++) begin : g_cell
        t_rec w_prev_rec;
        logic w_prev_valid;
        logic w_prev_ge;
        t_rec w_next_rec;
        logic w_next_valid;

        if (g == 0) begin : g_head
            assign w_prev_rec   = '0;
            assign w_prev_valid = 1'b1;
            assign w_prev_ge    = 1'b1;
        end else begin : g_body
            assign w_prev_rec   = w_rec[g-1];
            assign w_prev_valid = w_valid[g-1];
            assign w_prev_ge    = w_ge[g-1];
        end

        if (g == STORE_DEPTH - 1) begin : g_tail
            assign w_next_rec   = '0;
            assign w_next_valid = 1'b0;
        end else begin : g_mid
            assign w_next_rec   = w_rec[g+1];
            assign w_next_valid = w_valid[g+1];
        end

        tsrw_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_new        (w_new),
            .i_prev_rec   (w_prev_rec),
            .i_prev_valid (w_prev_valid),
            .i_prev_ge    (w_prev_ge),
            .i_next_rec   (w_next_rec),
            .i_next_valid (w_next_valid),
            .o_rec        (w_rec[g]),
            .o_valid      (w_valid[g]),
            .o_ge         (w_ge[g])
        );
    end

    // Sequence: insert, release check, drain and end marker
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_last_rel = r_last_rel;
        n_failed   = r_failed;
        w_ctl      = '0;
        n_ovalid   = r_ovalid && i_out_stall;
        n_okind    = r_okind;
        n_okey     = r_okey;
        n_otag     = r_otag;
        n_ofail    = r_ofail;
        n_olast    = r_olast;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_mode) begin
                        n_state = ST_DRAIN;
                    end else if (!r_failed && !w_full) begin
                        w_ctl.insert = 1'b1;
                        n_count      = r_count + CNT_W'(1);
                        n_state      = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (!w_reach) begin
                    n_state = ST_IDLE;
                end else if (w_ofree) begin
                    n_ovalid = 1'b1;
                    n_ofail  = 1'b0;
                    n_olast  = 1'b1;
                    n_state  = ST_IDLE;
                    if (r_last_rel > w_rec[0].key) begin
                        // Window too small: drop everything for this run
                        w_ctl.clear = 1'b1;
                        n_count     = '0;
                        n_failed    = 1'b1;
                        n_okind     = KIND_ERROR;
                        n_okey      = '0;
                        n_otag      = '0;
                    end else begin
                        w_ctl.pop  = 1'b1;
                        n_count    = r_count - CNT_W'(1);
                        n_last_rel = w_rec[0].key;
                        n_okind    = KIND_PACKET;
                        n_okey     = w_rec[0].key;
                        n_otag     = w_rec[0].tag;
                    end
                end
            end
            ST_DRAIN: begin
                if (w_ofree) begin
                    n_ovalid = 1'b1;
                    if (r_count != '0) begin
                        w_ctl.pop = 1'b1;
                        n_count   = r_count - CNT_W'(1);
                        n_okind   = KIND_PACKET;
                        n_okey    = w_rec[0].key;
                        n_otag    = w_rec[0].tag;
                        n_ofail   = 1'b0;
                        n_olast   = 1'b0;
                    end else begin
                        // End marker closes the run
                        n_okind    = KIND_END;
                        n_okey     = '0;
                        n_otag     = '0;
                        n_ofail    = r_failed;
                        n_olast    = 1'b1;
                        n_failed   = 1'b0;
                        n_last_rel = '0;
                        n_state    = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_last_rel <= '0;
            r_failed   <= 1'b0;
            r_window   <= WINDOW_RESET;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_last_rel <= n_last_rel;
            r_failed   <= n_failed;
            r_ovalid   <= n_ovalid;
            if (i_cfg_we) begin
                r_window <= i_cfg_data;
            end
        end
    end

    // Output beat payload
    always_ff @(posedge i_clk) begin
        r_okind <= n_okind;
        r_okey  <= n_okey;
        r_otag  <= n_otag;
        r_ofail <= n_ofail;
        r_olast <= n_olast;
    end

    assign o_out_valid   = r_ovalid;
    assign o_kind        = r_okind;
    assign o_out_seconds = r_okey[KEY_W-1:MIC_W];
    assign o_out_micros  = r_okey[MIC_W-1:0];
    assign o_out_tag     = r_otag;
    assign o_run_failed  = r_ofail;
    assign o_last        = r_olast;

    // Occupied cells always form a prefix of the chain
    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & (w_valid >> 1)) == (w_valid >> 1))
        else $error("cell occupancy is not a prefix");

    // Fill count tracks the occupied cells
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == 32'(r_count))
        else $error("fill count differs from occupied cells");

    // An end item starts the drain
    a_end_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_mode) |=> (r_state == ST_DRAIN))
        else $error("end item did not start the drain");

    // After a failed run check the chain is empty
    a_error_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK && w_ctl.clear) |=> (w_valid == '0 && r_failed))
        else $error("error release left records in the chain");

endmodule
